// ===== hw/rtl/pdg_pkg.sv =====
package pdg_pkg;

  localparam int LOG_TABLE_BITS_DEF = 8;
  localparam int EXP_TABLE_BITS_DEF = 8;

  localparam int CAP_W   = 24;
  localparam int EXPO_W  = 16;
  localparam int CUR_W   = 16;
  localparam int DUR_W   = 16;
  localparam int RES_W   = 24;
  localparam int TOT_W   = 32;
  localparam int MANT_W  = 31;
  localparam int LG_W    = 21;
  localparam int PROD_W  = 38;
  localparam int SH_W    = 10;
  localparam int DIV_W   = 64;
  localparam int REM_W   = 32;
  localparam int STEP_W  = 7;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 24'd30720;
  localparam logic [EXPO_W-1:0] EXPO_RESET = 16'd4915;
  localparam logic [RES_W-1:0]  MAX24      = 24'hFFFFFF;
  localparam logic [TOT_W-1:0]  MAX32      = 32'hFFFFFFFF;
  localparam logic [15:0]       PCT_SCALE  = 16'd25600;
  localparam logic [63:0]       ONE_Q30    = 64'd1 << 30;

  // configuration register indexes
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_LOG, S_EXP, S_MUL, S_NOW, S_HDIV, S_PLD, S_PDIV, S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  dividend;
    logic [REM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
  } div_stat_t;

  typedef struct packed {
    logic [RES_W-1:0] val;
    logic             hit;
  } sat_res_t;

  function automatic logic [63:0] isqrt_f(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v = v_in;
    res = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // log2(1 + k/2^bits) fraction in q.16, by repeated squaring in q1.30
  function automatic logic [15:0] log_rom_f(input int k, input int bits);
    logic [63:0] x;
    logic [15:0] o;
    x = ONE_Q30 + (64'(k) << (30 - bits));
    o = '0;
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      o = {o[14:0], 1'b0};
      if (x >= 2 * ONE_Q30) begin
        x = x >> 1;
        o[0] = 1'b1;
      end
    end
    return o;
  endfunction

  // 2^(k/2^bits) mantissa in q1.30
  function automatic logic [MANT_W-1:0] exp_rom_f(input int k, input int bits);
    logic [63:0] root;
    logic [63:0] m;
    root = 2 * ONE_Q30;
    m = ONE_Q30;
    for (int i = 1; i <= bits; i++) begin
      root = isqrt_f(root << 30);
      if (((k >> (bits - i)) & 1) != 0) m = (m * root) >> 30;
    end
    return m[MANT_W-1:0];
  endfunction

  // shift left by s (right when negative), clamp to 24 bits
  function automatic sat_res_t shift_sat(input logic [63:0] v,
                                         input logic signed [SH_W-1:0] s);
    sat_res_t r;
    logic [SH_W-1:0] sh;
    logic [63:0] w;
    r.val = '0;
    r.hit = 1'b0;
    sh = s[SH_W-1] ? SH_W'(-s) : SH_W'(s);
    if (!s[SH_W-1]) begin
      if (v != '0) begin
        if (sh >= SH_W'(RES_W)) begin
          r.val = MAX24;
          r.hit = 1'b1;
        end else begin
          w = v >> (SH_W'(RES_W) - sh);
          if (w != '0) begin
            r.val = MAX24;
            r.hit = 1'b1;
          end else begin
            r.val = RES_W'(v << sh);
          end
        end
      end
    end else begin
      w = v >> sh;
      if (w > 64'(MAX24)) begin
        r.val = MAX24;
        r.hit = 1'b1;
      end else begin
        r.val = w[RES_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/pdg_if.sv =====
interface pdg_in_if import pdg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CUR_W-1:0] current_amps;
  logic [DUR_W-1:0] duration_hours;

  modport source (output valid, output current_amps, output duration_hours, input ready);
  modport sink (input valid, input current_amps, input duration_hours, output ready);
endinterface

interface pdg_out_if import pdg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] consumed_now;
  logic [TOT_W-1:0] consumed_total;
  logic [RES_W-1:0] percent_used;
  logic [RES_W-1:0] hours_at_current;
  logic             zero_current;
  logic             saturated;

  modport source (output valid, output consumed_now, output consumed_total,
                  output percent_used, output hours_at_current, output zero_current,
                  output saturated, input ready);
  modport sink (input valid, input consumed_now, input consumed_total,
                input percent_used, input hours_at_current, input zero_current,
                input saturated, output ready);
endinterface

// ===== hw/rtl/pdg_div.sv =====
module pdg_div import pdg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output div_stat_t        stat,
  output logic [DIV_W-1:0] quotient
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_next;
  logic [DIV_W-1:0]  quo;
  logic [REM_W-1:0]  dvs;
  logic [REM_W:0]    rem_sh;
  logic [REM_W:0]    diff;
  logic              ge;

  // one restoring step per cycle
  always_comb begin
    rem_sh   = {rem, quo[DIV_W-1]};
    diff     = rem_sh - {1'b0, dvs};
    ge       = rem_sh >= {1'b0, dvs};
    rem_next = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.steps;
    end else if (busy) begin
      cnt <= cnt - STEP_W'(1);
      if (cnt == STEP_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign quotient  = quo;

endmodule

// ===== hw/rtl/peukert_discharge_gauge_top.sv =====
// Peukert-law fuel gauge. Each input transfer carries a current (Q8.8 A) and a
// duration (Q8.8 h); each one yields exactly one output transfer with the
// effective consumption I^p*D, the saturating running total, the percent of
// rated capacity used and the run time at this current. The power comes from
// a log2 table, one 21x17 multiply and an exp2 table. The two quotients share
// one restoring divider that retires one bit per cycle, 63 steps for the run
// time and 47 for the percentage; with zero current the run-time division is
// skipped. in_ch.ready is high only while the sequencer is idle; the output
// register holds a finished result until it is taken, so the next item can be
// accepted meanwhile. Configuration writes of zero, or to an unknown index,
// are ignored.
module peukert_discharge_gauge_top import pdg_pkg::*; #(
  parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF,
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  pdg_in_if.sink           in_ch,
  pdg_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int LOG_DEPTH = 1 << LOG_TABLE_BITS;
  localparam int EXP_DEPTH = 1 << EXP_TABLE_BITS;

  // constant tables, worked out at elaboration
  logic [15:0]       log_tab [LOG_DEPTH];
  logic [MANT_W-1:0] exp_tab [EXP_DEPTH];

  for (genvar g = 0; g < LOG_DEPTH; g++) begin : g_log
    assign log_tab[g] = log_rom_f(g, LOG_TABLE_BITS);
  end
  for (genvar g = 0; g < EXP_DEPTH; g++) begin : g_exp
    assign exp_tab[g] = exp_rom_f(g, EXP_TABLE_BITS);
  end

  state_t state, state_next;

  // configuration
  logic [CAP_W-1:0]  cap;
  logic [EXPO_W-1:0] expo;

  // running total
  logic [TOT_W-1:0] acc;

  // per-item working registers
  logic [CUR_W-1:0]         cur_r;
  logic [DUR_W-1:0]         dur_r;
  logic                     zero_r;
  logic signed [PROD_W-1:0] prod;
  logic [MANT_W-1:0]        mant_r;
  logic signed [SH_W-1:0]   q_r;
  logic [MANT_W+DUR_W-1:0]  vnow;
  logic [RES_W-1:0]         now_r;
  logic [TOT_W-1:0]         total_r;
  logic                     hit_r;
  logic [RES_W-1:0]         hours_r;
  logic [RES_W-1:0]         pct_r;

  // output register
  logic             out_valid;
  logic [RES_W-1:0] o_now;
  logic [TOT_W-1:0] o_total;
  logic [RES_W-1:0] o_pct;
  logic [RES_W-1:0] o_hours;
  logic             o_zero;
  logic             o_sat;

  div_req_t         div_req;
  div_stat_t        div_stat;
  logic [DIV_W-1:0] div_q;

  pdg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .stat     (div_stat),
    .quotient (div_q)
  );

  logic                      accept;
  logic                      out_load;
  logic                      out_free;

  // log2 of the current
  logic [3:0]                msb;
  logic [CUR_W-1:0]          norm;
  logic [LOG_TABLE_BITS-1:0] lkey;
  logic signed [LG_W-1:0]    lg;
  logic [4:0]                lg_int;

  // exponent split
  logic [EXP_TABLE_BITS-1:0] ekey;

  // run time shift split: t = -q, a = clamp(t, 0, 9)
  logic signed [SH_W-1:0]    t_sh;
  logic [3:0]                a_sh;
  logic signed [SH_W-1:0]    h_sh;

  sat_res_t                  now_sat;
  sat_res_t                  hrs_sat;
  logic [RES_W-1:0]          now_c;
  logic [TOT_W:0]            sum_c;
  logic [TOT_W-1:0]          total_c;
  logic [TOT_W+15:0]         pct_num;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign out_load = (state == S_DONE) && out_free;

  always_comb begin
    msb = '0;
    for (int i = 0; i < CUR_W; i++) begin
      if (cur_r[i]) msb = 4'(i);
    end
    norm   = cur_r << (4'd15 - msb);
    lkey   = norm[CUR_W-2 -: LOG_TABLE_BITS];
    lg_int = {1'b0, msb} - 5'd8;
    lg     = $signed({lg_int, log_tab[lkey]});
  end

  // floor(e / 2^16) and the top fraction bits of e = floor(lg * p / 2^12)
  assign ekey = prod[27 -: EXP_TABLE_BITS];

  always_comb begin
    t_sh = -q_r;
    if (t_sh > 10'sd9) a_sh = 4'd9;
    else if (t_sh < 10'sd0) a_sh = 4'd0;
    else a_sh = t_sh[3:0];
    h_sh = t_sh - $signed({6'b0, a_sh});
  end

  always_comb begin
    now_sat = shift_sat(64'(vnow), q_r - 10'sd30);
    hrs_sat = shift_sat(div_q, h_sh);
    now_c   = zero_r ? '0 : now_sat.val;
    sum_c   = {1'b0, acc} + {9'b0, now_c};
    total_c = sum_c[TOT_W] ? MAX32 : sum_c[TOT_W-1:0];
    pct_num = (TOT_W+16)'(total_r) * (TOT_W+16)'(PCT_SCALE);
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_LOG;
      S_LOG:  state_next = S_EXP;
      S_EXP:  state_next = S_MUL;
      S_MUL:  state_next = S_NOW;
      S_NOW:  state_next = zero_r ? S_PLD : S_HDIV;
      S_HDIV: if (!div_stat.busy) state_next = S_PLD;
      S_PLD:  state_next = S_PDIV;
      S_PDIV: if (!div_stat.busy) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer: outputs toward the channel and the divider
  always_comb begin
    in_ch.ready      = 1'b0;
    div_req.start    = 1'b0;
    div_req.steps    = '0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state)
      S_IDLE: in_ch.ready = 1'b1;
      S_NOW: begin
        // capacity * 2^(30+a) / mantissa, dividend below 2^63
        div_req.start    = !zero_r;
        div_req.steps    = STEP_W'(63);
        div_req.dividend = (DIV_W'(cap) << (30 + a_sh)) << 1;
        div_req.divisor  = REM_W'(mant_r);
      end
      S_PLD: begin
        // 25600 * total / capacity, 47-bit dividend
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(47);
        div_req.dividend = DIV_W'(pct_num) << 17;
        div_req.divisor  = REM_W'(cap);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap       <= CAP_RESET;
      expo      <= EXPO_RESET;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == REG_CAPACITY && cfg_wdata != '0) cap <= cfg_wdata;
      if (cfg_we && cfg_index == REG_EXPONENT && cfg_wdata[EXPO_W-1:0] != '0) begin
        expo <= cfg_wdata[EXPO_W-1:0];
      end
      if (state == S_NOW) acc <= total_c;
      if (out_load) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur_r  <= in_ch.current_amps;
        dur_r  <= in_ch.duration_hours;
        zero_r <= in_ch.current_amps == '0;
      end
      S_LOG: prod <= PROD_W'(lg) * PROD_W'($signed({1'b0, expo}));
      S_EXP: begin
        mant_r <= exp_tab[ekey];
        q_r    <= prod[PROD_W-1 -: SH_W];
      end
      S_MUL: vnow <= (MANT_W+DUR_W)'(mant_r) * (MANT_W+DUR_W)'(dur_r);
      S_NOW: begin
        now_r   <= now_c;
        total_r <= total_c;
        hit_r   <= zero_r || (!zero_r && now_sat.hit) || total_c == MAX32;
        hours_r <= MAX24;
      end
      S_HDIV: begin
        if (!div_stat.busy) begin
          hours_r <= hrs_sat.val;
          hit_r   <= hit_r || hrs_sat.hit;
        end
      end
      S_PDIV: begin
        if (!div_stat.busy) begin
          if (div_q > DIV_W'(MAX24)) begin
            pct_r <= MAX24;
            hit_r <= 1'b1;
          end else begin
            pct_r <= div_q[RES_W-1:0];
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      o_now   <= now_r;
      o_total <= total_r;
      o_pct   <= pct_r;
      o_hours <= hours_r;
      o_zero  <= zero_r;
      o_sat   <= hit_r;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.consumed_now     = o_now;
  assign out_ch.consumed_total   = o_total;
  assign out_ch.percent_used     = o_pct;
  assign out_ch.hours_at_current = o_hours;
  assign out_ch.zero_current     = o_zero;
  assign out_ch.saturated        = o_sat;

endmodule
